// File: src/bitmap_first_fit_page_allocator_macros.svh
// Assertion helpers shared by the allocator RTL.
// Each helper samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef BITMAP_FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFFPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BFFPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bffpa_pkg.sv
package bffpa_pkg;

    // Pool geometry.
    localparam int MAX_PAGES = 256;
    localparam int PAGE_W = $clog2(MAX_PAGES);
    localparam int CNT_W = PAGE_W + 1;
    localparam logic [CNT_W-1:0] POOL_MAX = CNT_W'(MAX_PAGES);

    // One bitmap word per page: taken flag and end-of-allocation flag.
    localparam int PAGE_WORD_W = 2;
    localparam int TAKEN_BIT = 0;
    localparam int END_BIT = 1;

    // Commands.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE = 1'b1;

    // Result status codes.
    localparam int STATUS_W = 3;
    localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ENOUGH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_RUN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

    // Microprogram step addresses.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] S_IDLE = 3'd0;
    localparam logic [STEP_W-1:0] S_DISP = 3'd1;
    localparam logic [STEP_W-1:0] S_SCAN = 3'd2;
    localparam logic [STEP_W-1:0] S_DECIDE = 3'd3;
    localparam logic [STEP_W-1:0] S_BRANCH = 3'd4;
    localparam logic [STEP_W-1:0] S_MARK = 3'd5;
    localparam logic [STEP_W-1:0] S_WALK = 3'd6;
    localparam logic [STEP_W-1:0] S_OUT = 3'd7;

    // Datapath operations.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD = 3'd1;
    localparam logic [OP_W-1:0] OP_SCAN = 3'd2;
    localparam logic [OP_W-1:0] OP_DECIDE = 3'd3;
    localparam logic [OP_W-1:0] OP_MARK = 3'd4;
    localparam logic [OP_W-1:0] OP_WALK = 3'd5;
    localparam logic [OP_W-1:0] OP_EMIT = 3'd6;

    // Jump condition selects.
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_ACCEPT = 3'd0;
    localparam logic [COND_W-1:0] C_POOL_EMPTY = 3'd1;
    localparam logic [COND_W-1:0] C_LAST = 3'd2;
    localparam logic [COND_W-1:0] C_GO_MARK = 3'd3;
    localparam logic [COND_W-1:0] C_GO_WALK = 3'd4;
    localparam logic [COND_W-1:0] C_REM_LAST = 3'd5;
    localparam logic [COND_W-1:0] C_WALK_END = 3'd6;
    localparam logic [COND_W-1:0] C_OUT_FREE = 3'd7;

    // One control word: operation, condition, target when true, target when false.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] tgt_t;
        logic [STEP_W-1:0] tgt_f;
    } ucode_t;

    // Condition flags from the datapath to the sequencer.
    typedef struct packed {
        logic accept;
        logic pool_empty;
        logic last;
        logic go_mark;
        logic go_walk;
        logic rem_last;
        logic walk_end;
        logic out_free;
    } cond_t;

    // Control store.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            S_IDLE: w = '{OP_LOAD, C_ACCEPT, S_DISP, S_IDLE};
            S_DISP: w = '{OP_NONE, C_POOL_EMPTY, S_DECIDE, S_SCAN};
            S_SCAN: w = '{OP_SCAN, C_LAST, S_DECIDE, S_SCAN};
            S_DECIDE: w = '{OP_DECIDE, C_GO_MARK, S_MARK, S_BRANCH};
            S_BRANCH: w = '{OP_NONE, C_GO_WALK, S_WALK, S_OUT};
            S_MARK: w = '{OP_MARK, C_REM_LAST, S_OUT, S_MARK};
            S_WALK: w = '{OP_WALK, C_WALK_END, S_OUT, S_WALK};
            S_OUT: w = '{OP_EMIT, C_OUT_FREE, S_IDLE, S_OUT};
            default: w = '{OP_NONE, C_ACCEPT, S_IDLE, S_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: src/bffpa_if.sv
// Request channel: one allocate or free command per word.
interface bffpa_req_if;
    import bffpa_pkg::*;

    logic valid;
    logic ready;
    logic cmd;
    logic [CNT_W-1:0] req_count;
    logic [PAGE_W-1:0] free_index;

    modport source (output valid, output cmd, output req_count, output free_index,
                    input ready);
    modport sink (input valid, input cmd, input req_count, input free_index,
                  output ready);
endinterface

// Response channel: one result word per request.
interface bffpa_rsp_if;
    import bffpa_pkg::*;

    logic valid;
    logic ready;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0] first_page;
    logic [CNT_W-1:0] free_count;
    logic [CNT_W-1:0] taken_count;

    modport source (output valid, output status, output first_page, output free_count,
                    output taken_count, input ready);
    modport sink (input valid, input status, input first_page, input free_count,
                  input taken_count, output ready);
endinterface

// Configuration channel: pool size register write.
interface bffpa_cfg_if;
    import bffpa_pkg::*;

    logic valid;
    logic ready;
    logic [CNT_W-1:0] pool_pages;

    modport source (output valid, output pool_pages, input ready);
    modport sink (input valid, input pool_pages, output ready);
endinterface

// File: src/bffpa_ram.sv
module bffpa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/bffpa_useq.sv
module bffpa_useq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bffpa_pkg::cond_t                cond,
    output bffpa_pkg::ucode_t               uword,
    output logic [bffpa_pkg::STEP_W-1:0]    step
);
    import bffpa_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic hit;

    // Current control word comes straight from the control store.
    assign uword = ucode_rom(step_reg);
    assign step = step_reg;

    // Select the condition named by the control word.
    always_comb
    begin
        case (uword.cond)
            C_ACCEPT: hit = cond.accept;
            C_POOL_EMPTY: hit = cond.pool_empty;
            C_LAST: hit = cond.last;
            C_GO_MARK: hit = cond.go_mark;
            C_GO_WALK: hit = cond.go_walk;
            C_REM_LAST: hit = cond.rem_last;
            C_WALK_END: hit = cond.walk_end;
            C_OUT_FREE: hit = cond.out_free;
            default: hit = 1'b0;
        endcase
        step_next = hit ? uword.tgt_t : uword.tgt_f;
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// File: src/bitmap_first_fit_page_allocator.sv
// Sequence: with P pages in the pool, an allocate scans all P pages, decides, then marks
// an R-page run; a free scans, decides, then walks W pages up to the end mark or pool end.
// One request at a time; each request scans the whole pool once through the
// bitmap RAM read port, so P sets the rate.
// Reset: pool size returns to 256 and per-page valid flops make every page read as
// free with no end mark at once; no clearing pass is needed.
`include "bitmap_first_fit_page_allocator_macros.svh"

module bitmap_first_fit_page_allocator (
    input logic clk,
    input logic rst_n,
    bffpa_cfg_if.sink cfg,
    bffpa_req_if.sink req,
    bffpa_rsp_if.source rsp
);
    import bffpa_pkg::*;

    // Sequencer interface.
    ucode_t uw;
    cond_t cond;
    logic [STEP_W-1:0] step;

    // Bitmap RAM interface.
    logic ram_we;
    logic [PAGE_WORD_W-1:0] ram_wdata;
    logic [PAGE_WORD_W-1:0] ram_rdata;
    logic [MAX_PAGES-1:0] pvalid_reg;
    logic rd_valid_reg;
    logic rd_taken;
    logic rd_end;

    // Datapath registers.
    logic [CNT_W-1:0] pool_reg, pool_next;
    logic cmd_reg, cmd_next;
    logic [CNT_W-1:0] req_reg, req_next;
    logic [PAGE_W-1:0] fidx_reg, fidx_next;
    logic [PAGE_W-1:0] idx_reg, idx_next;
    logic [PAGE_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] run_reg, run_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic found_reg, found_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // Output word registers.
    logic out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] o_status_reg, o_status_next;
    logic [PAGE_W-1:0] o_first_reg, o_first_next;
    logic [CNT_W-1:0] o_free_reg, o_free_next;
    logic [CNT_W-1:0] o_taken_reg, o_taken_next;

    // Derived values.
    logic [CNT_W-1:0] pool;
    logic [CNT_W-1:0] pool_last;
    logic [CNT_W-1:0] run_inc;
    logic [CNT_W-1:0] run_start;
    logic is_last;
    logic count_bad;
    logic in_accept;
    logic out_accept;

    bffpa_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .uword (uw),
        .step  (step)
    );

    bffpa_ram #(
        .WIDTH (PAGE_WORD_W),
        .DEPTH (MAX_PAGES)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_next),
        .rdata (ram_rdata)
    );

    // Handshakes.
    assign req.ready = (step == S_IDLE);
    assign cfg.ready = (step == S_IDLE) && !out_valid_reg;
    assign in_accept = req.valid && req.ready;
    assign out_accept = out_valid_reg && rsp.ready;

    // Effective pool and loop bounds.
    assign pool = (pool_reg > POOL_MAX) ? POOL_MAX : pool_reg;
    assign pool_last = pool - CNT_W'(1);
    assign is_last = ({1'b0, idx_reg} == pool_last);
    assign run_inc = run_reg + CNT_W'(1);
    assign run_start = {1'b0, idx_reg} + CNT_W'(1) - req_reg;
    assign count_bad = (req_reg == '0) || (req_reg > pool);

    // Pages never written since reset read as free with no end mark.
    assign rd_taken = rd_valid_reg && ram_rdata[TAKEN_BIT];
    assign rd_end = rd_valid_reg && ram_rdata[END_BIT];

    // Conditions for the sequencer.
    always_comb
    begin
        cond.accept = in_accept;
        cond.pool_empty = (pool == '0);
        cond.last = is_last;
        cond.go_mark = (cmd_reg == CMD_ALLOC) && !count_bad && found_reg;
        cond.go_walk = (cmd_reg == CMD_FREE) && ({1'b0, fidx_reg} < pool);
        cond.rem_last = (rem_reg == CNT_W'(1));
        cond.walk_end = rd_end || is_last;
        cond.out_free = !out_valid_reg || rsp.ready;
    end

    // Datapath driven by the current control word.
    always_comb
    begin
        pool_next = pool_reg;
        cmd_next = cmd_reg;
        req_next = req_reg;
        fidx_next = fidx_reg;
        idx_next = idx_reg;
        start_next = start_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        rem_next = rem_reg;
        found_next = found_reg;
        status_next = status_reg;
        out_valid_next = out_valid_reg;
        o_status_next = o_status_reg;
        o_first_next = o_first_reg;
        o_free_next = o_free_reg;
        o_taken_next = o_taken_reg;
        ram_we = 1'b0;
        ram_wdata = '0;

        if (cfg.valid && cfg.ready)
        begin
            pool_next = cfg.pool_pages;
        end

        if (out_accept)
        begin
            out_valid_next = 1'b0;
        end

        case (uw.op)
            // Capture the request and aim the read port at page zero.
            OP_LOAD:
            begin
                idx_next = '0;
                if (in_accept)
                begin
                    cmd_next = req.cmd;
                    req_next = req.req_count;
                    fidx_next = req.free_index;
                    cnt_next = '0;
                    run_next = '0;
                    found_next = 1'b0;
                end
            end
            // Count free pages and remember where the first fitting run starts.
            OP_SCAN:
            begin
                if (!rd_taken)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    run_next = run_inc;
                    if (!found_reg && (run_inc == req_reg))
                    begin
                        found_next = 1'b1;
                        start_next = run_start[PAGE_W-1:0];
                    end
                end
                else
                begin
                    run_next = '0;
                end
                idx_next = idx_reg + PAGE_W'(1);
            end
            // Settle the status and point at the first page to modify.
            OP_DECIDE:
            begin
                rem_next = req_reg;
                if (cmd_reg == CMD_ALLOC)
                begin
                    idx_next = start_reg;
                    if (count_bad)
                    begin
                        status_next = ST_BAD_COUNT;
                    end
                    else if (found_reg)
                    begin
                        status_next = ST_OK;
                        cnt_next = cnt_reg - req_reg;
                    end
                    else if (req_reg > cnt_reg)
                    begin
                        status_next = ST_NOT_ENOUGH;
                    end
                    else
                    begin
                        status_next = ST_NO_RUN;
                    end
                end
                else
                begin
                    idx_next = fidx_reg;
                    status_next = ({1'b0, fidx_reg} < pool) ? ST_OK : ST_BAD_INDEX;
                end
            end
            // Mark the granted run taken, end mark on its last page.
            OP_MARK:
            begin
                ram_we = 1'b1;
                ram_wdata[TAKEN_BIT] = 1'b1;
                ram_wdata[END_BIT] = rd_end || (rem_reg == CNT_W'(1));
                rem_next = rem_reg - CNT_W'(1);
                idx_next = idx_reg + PAGE_W'(1);
            end
            // Release pages up to and including the first end mark.
            OP_WALK:
            begin
                ram_we = 1'b1;
                ram_wdata = '0;
                if (rd_taken)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                idx_next = idx_reg + PAGE_W'(1);
            end
            // Load the result word once the output register is free.
            OP_EMIT:
            begin
                if (cond.out_free)
                begin
                    out_valid_next = 1'b1;
                    o_status_next = status_reg;
                    o_first_next = ((cmd_reg == CMD_ALLOC) && (status_reg == ST_OK))
                                   ? start_reg : '0;
                    o_free_next = cnt_reg;
                    o_taken_next = pool - cnt_reg;
                end
            end
            OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg <= POOL_MAX;
            out_valid_reg <= 1'b0;
            pvalid_reg <= '0;
            rd_valid_reg <= 1'b0;
            idx_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            pool_reg <= pool_next;
            out_valid_reg <= out_valid_next;
            idx_reg <= idx_next;
            found_reg <= found_next;
            rd_valid_reg <= pvalid_reg[idx_next];
            if (ram_we)
            begin
                pvalid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        req_reg <= req_next;
        fidx_reg <= fidx_next;
        start_reg <= start_next;
        cnt_reg <= cnt_next;
        run_reg <= run_next;
        rem_reg <= rem_next;
        status_reg <= status_next;
        o_status_reg <= o_status_next;
        o_first_reg <= o_first_next;
        o_free_reg <= o_free_next;
        o_taken_reg <= o_taken_next;
    end

    // Result port.
    assign rsp.valid = out_valid_reg;
    assign rsp.status = o_status_reg;
    assign rsp.first_page = o_first_reg;
    assign rsp.free_count = o_free_reg;
    assign rsp.taken_count = o_taken_reg;

    // Marking and walking never touch pages beyond the pool end.
    `BFFPA_ASSERT_NOW(a_mark_in_pool, step == S_MARK, {1'b0, idx_reg} < pool,
                      "mark step addresses a page beyond the pool")
    `BFFPA_ASSERT_NOW(a_walk_in_pool, step == S_WALK, {1'b0, idx_reg} < pool,
                      "walk step addresses a page beyond the pool")
    // The free page count never exceeds the pool when a result is formed.
    `BFFPA_ASSERT_NOW(a_cnt_bound, step == S_OUT, cnt_reg <= pool,
                      "free page count exceeds pool size")
    // A stalled result keeps the sequencer parked on the output step.
    `BFFPA_ASSERT_NEXT(a_out_hold, (step == S_OUT) && out_valid_reg && !rsp.ready,
                       step == S_OUT, "sequencer left output step while result stalled")

endmodule
